FILE: rtl/smar_pkg.sv
// shared constants, types and command/status structs for the scan smoother
`timescale 1ns / 1ps
`default_nettype none
package smar_pkg;

   localparam int MAX_RADIUS     = 31;
   localparam int SAMPLE_BITS    = 16;
   localparam int RADIUS_BITS    = $clog2(MAX_RADIUS + 1);
   localparam int RING_DEPTH     = 64;
   localparam int ADDR_BITS      = $clog2(RING_DEPTH);
   localparam int COUNT_BITS     = ADDR_BITS + 1;
   localparam int TAP_BITS       = ADDR_BITS + 2;
   localparam int DIVISOR_BITS   = RADIUS_BITS + 1;
   localparam int SUM_BITS       = SAMPLE_BITS + $clog2(2 * MAX_RADIUS + 1);
   localparam int DIV_CNT_BITS   = $clog2(SUM_BITS + 1);
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = RADIUS_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMOOTH_ENABLE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMOOTH_RADIUS = 1'b1;
   localparam logic [RADIUS_BITS-1:0]    RADIUS_RESET      = RADIUS_BITS'(1);

   typedef enum logic [1:0] {
      SRC_PASS,
      SRC_AVG,
      SRC_RAM
   } out_src_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SUM,
      ST_SUM_DRAIN,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_EMIT_AVG,
      ST_EMIT_PASS,
      ST_SHORT_RD,
      ST_SHORT_EMIT
   } state_type;

   typedef struct packed {
      logic                   smooth_enable;
      logic [RADIUS_BITS-1:0] smooth_radius;
   } cfg_type;

   typedef struct packed {
      logic        accept;
      logic        sum_first;
      logic        sum_next;
      logic        read_tap;
      logic        short_first;
      logic        short_next;
      logic        read_short;
      logic        div_load;
      logic        div_step;
      logic        load_out;
      out_src_type out_src;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic eos;
      logic scan_short;
      logic tap_last;
      logic div_last;
      logic avg_last;
      logic short_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/smar_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module smar_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/smar_ctrl.sv
// sequencing state machine for the scan smoother
`timescale 1ns / 1ps
`default_nettype none
module smar_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire smar_pkg::status_type status,
   output smar_pkg::cmd_type         cmd
);
   import smar_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!status.enable) begin
               state_in = ST_EMIT_PASS;
            end else if (status.scan_short) begin
               state_in = status.eos ? ST_SHORT_RD : ST_IDLE;
            end else begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (status.tap_last) begin
               state_in = ST_SUM_DRAIN;
            end
         end
         ST_SUM_DRAIN: state_in = ST_DIV_LOAD;
         ST_DIV_LOAD:  state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (status.div_last) begin
               state_in = ST_EMIT_AVG;
            end
         end
         ST_EMIT_AVG: begin
            if (status.out_free) begin
               state_in = status.avg_last ? ST_IDLE : ST_SUM;
            end
         end
         ST_EMIT_PASS: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SHORT_RD: state_in = ST_SHORT_EMIT;
         ST_SHORT_EMIT: begin
            if (status.out_free) begin
               state_in = status.short_last ? ST_IDLE : ST_SHORT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd         = '0;
      cmd.out_src = SRC_PASS;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_DECIDE: begin
            cmd.sum_first   = status.enable && !status.scan_short;
            cmd.short_first = status.enable && status.scan_short && status.eos;
         end
         ST_SUM:      cmd.read_tap = 1'b1;
         ST_DIV_LOAD: cmd.div_load = 1'b1;
         ST_DIV_RUN:  cmd.div_step = 1'b1;
         ST_EMIT_AVG: begin
            cmd.out_src  = SRC_AVG;
            cmd.load_out = status.out_free;
            cmd.sum_next = status.out_free && !status.avg_last;
         end
         ST_EMIT_PASS: begin
            cmd.out_src  = SRC_PASS;
            cmd.load_out = status.out_free;
         end
         ST_SHORT_RD: cmd.read_short = 1'b1;
         ST_SHORT_EMIT: begin
            cmd.out_src    = SRC_RAM;
            cmd.load_out   = status.out_free;
            cmd.short_next = status.out_free && !status.short_last;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/smar_dp.sv
// datapath: sample ring, tap address and reflection, accumulator, divider, output word
`timescale 1ns / 1ps
`default_nettype none
module smar_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire smar_pkg::cfg_type                   cfg,
   input  wire smar_pkg::cmd_type                   cmd,
   output smar_pkg::status_type                     status,
   input  wire logic [smar_pkg::SAMPLE_BITS-1:0]    req_distance,
   input  wire logic                                req_end_of_scan,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [smar_pkg::SAMPLE_BITS-1:0]    rsp_smoothed,
   output logic                                     rsp_last_of_scan,
   output logic                                     rsp_short_scan
);
   import smar_pkg::*;

   logic [ADDR_BITS-1:0]         pos_ff;
   logic [COUNT_BITS-1:0]        seen_ff;
   logic [COUNT_BITS-1:0]        n_ff;
   logic [ADDR_BITS-1:0]         base_ff;
   logic [SAMPLE_BITS-1:0]       sample_ff;
   logic                         eos_ff;
   logic [ADDR_BITS-1:0]         i_ff;
   logic signed [TAP_BITS-1:0]   tap_ff;
   logic [SUM_BITS-1:0]          acc_ff;
   logic                         rd_valid_ff;
   logic [DIVISOR_BITS-1:0]      rem_ff;
   logic [SUM_BITS-1:0]          quo_ff;
   logic [DIV_CNT_BITS-1:0]      div_cnt_ff;
   logic                         rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]       rsp_smoothed_ff;
   logic                         rsp_last_ff;
   logic                         rsp_short_ff;

   logic [RADIUS_BITS-1:0]       k;
   logic [COUNT_BITS-1:0]        seen_inc;
   logic [COUNT_BITS-1:0]        n_minus1;
   logic [ADDR_BITS-1:0]         n_last;
   logic [COUNT_BITS-1:0]        first_i_wide;
   logic [ADDR_BITS-1:0]         first_i;
   logic [ADDR_BITS-1:0]         i_next;
   logic signed [TAP_BITS-1:0]   k_s;
   logic signed [TAP_BITS-1:0]   n_s;
   logic signed [TAP_BITS-1:0]   tap_first;
   logic signed [TAP_BITS-1:0]   tap_next;
   logic signed [TAP_BITS-1:0]   tap_end;
   logic [TAP_BITS-1:0]          refl;
   logic [ADDR_BITS-1:0]         rd_addr;
   logic                         rd_en;
   logic [SAMPLE_BITS-1:0]       rd_data;
   logic [DIVISOR_BITS-1:0]      divisor;
   logic [DIVISOR_BITS:0]        shifted;
   logic [DIVISOR_BITS:0]        diff;
   logic                         ge;
   logic                         out_free;
   logic [SAMPLE_BITS-1:0]       out_data;
   logic                         out_last;
   logic                         out_short;

   assign k            = cfg.smooth_radius;
   assign seen_inc     = (seen_ff == COUNT_BITS'(RING_DEPTH)) ? seen_ff
                                                              : seen_ff + COUNT_BITS'(1);
   assign n_minus1     = n_ff - COUNT_BITS'(1);
   assign n_last       = n_minus1[ADDR_BITS-1:0];
   assign first_i_wide = n_minus1 - COUNT_BITS'(k);
   assign first_i      = first_i_wide[ADDR_BITS-1:0];
   assign i_next       = i_ff + ADDR_BITS'(1);
   assign k_s          = $signed(TAP_BITS'(k));
   assign n_s          = $signed(TAP_BITS'(n_ff));
   assign tap_first    = $signed(TAP_BITS'(first_i)) - k_s;
   assign tap_next     = $signed(TAP_BITS'(i_next)) - k_s;
   assign tap_end      = $signed(TAP_BITS'(i_ff)) + k_s;

   // reflect-101 at both scan edges; only the low bits are used so wrap is harmless
   always_comb begin
      if (tap_ff < 0) begin
         refl = -tap_ff;
      end else if (tap_ff >= n_s) begin
         refl = (n_s <<< 1) - TAP_BITS'(2) - tap_ff;
      end else begin
         refl = tap_ff;
      end
   end

   assign rd_addr = base_ff + (cmd.read_short ? i_ff : refl[ADDR_BITS-1:0]);
   assign rd_en   = cmd.read_tap | cmd.read_short;

   smar_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (pos_ff),
      .wr_data (req_distance),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // restoring divide by the odd window length, one quotient bit per cycle
   assign divisor = {k, 1'b1};
   assign shifted = {rem_ff, quo_ff[SUM_BITS-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign ge      = shifted >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         seen_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.read_tap;
         if (cmd.accept) begin
            pos_ff  <= pos_ff + ADDR_BITS'(1);
            seen_ff <= req_end_of_scan ? '0 : seen_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_distance;
         eos_ff    <= req_end_of_scan;
         n_ff      <= seen_inc;
         base_ff   <= pos_ff + ADDR_BITS'(1) - seen_inc[ADDR_BITS-1:0];
      end

      if (cmd.sum_first) begin
         i_ff   <= first_i;
         tap_ff <= tap_first;
      end else if (cmd.sum_next || cmd.short_next) begin
         i_ff   <= i_next;
         tap_ff <= tap_next;
      end else if (cmd.short_first) begin
         i_ff <= '0;
      end else if (cmd.read_tap) begin
         tap_ff <= tap_ff + TAP_BITS'(1);
      end

      if (cmd.sum_first || cmd.sum_next) begin
         acc_ff <= '0;
      end else if (rd_valid_ff) begin
         acc_ff <= acc_ff + SUM_BITS'(rd_data);
      end

      if (cmd.div_load) begin
         rem_ff     <= '0;
         quo_ff     <= acc_ff;
         div_cnt_ff <= DIV_CNT_BITS'(SUM_BITS);
      end else if (cmd.div_step) begin
         rem_ff     <= ge ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
         quo_ff     <= {quo_ff[SUM_BITS-2:0], ge};
         div_cnt_ff <= div_cnt_ff - DIV_CNT_BITS'(1);
      end
   end

   // output word register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cmd.out_src)
         SRC_AVG: begin
            out_data  = quo_ff[SAMPLE_BITS-1:0];
            out_last  = eos_ff && (i_ff == n_last);
            out_short = 1'b0;
         end
         SRC_RAM: begin
            out_data  = rd_data;
            out_last  = i_ff == n_last;
            out_short = 1'b1;
         end
         default: begin
            out_data  = sample_ff;
            out_last  = eos_ff;
            out_short = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_smoothed_ff <= out_data;
         rsp_last_ff     <= out_last;
         rsp_short_ff    <= out_short;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_smoothed     = rsp_smoothed_ff;
   assign rsp_last_of_scan = rsp_last_ff;
   assign rsp_short_scan   = rsp_short_ff;

   assign status.enable     = cfg.smooth_enable;
   assign status.eos        = eos_ff;
   assign status.scan_short = n_ff <= COUNT_BITS'(k);
   assign status.tap_last   = tap_ff == tap_end;
   assign status.div_last   = div_cnt_ff == DIV_CNT_BITS'(1);
   assign status.avg_last   = !eos_ff || (i_ff == n_last);
   assign status.short_last = i_ff == n_last;
   assign status.out_free   = out_free;

endmodule
`default_nettype wire

FILE: rtl/scan_moving_average_reflect_unit.sv
// top level of the scan smoother: config registers, controller and datapath
`timescale 1ns / 1ps
`default_nettype none
// Centred moving average over one scan, window 2k+1, mirrored at the scan edges
// without repeating the edge sample. One sample word is taken at a time. With
// smoothing off a word passes through the decide and emit states to the output
// register. With smoothing on, the taps of each smoothed word are summed one per
// cycle through the single read port of the 64-entry sample ring, then the sum
// goes through a one-bit-per-cycle divider of 22 steps. An end-of-scan sample
// produces the last k+1 words of the scan in turn; a scan of k or fewer samples
// is replayed unsmoothed with short_scan set. The output register lets the next
// sample be accepted while the final word waits on rsp_stall.
module scan_moving_average_reflect_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [smar_pkg::SAMPLE_BITS-1:0]     req_distance,
   input  wire logic                                 req_end_of_scan,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [smar_pkg::SAMPLE_BITS-1:0]     rsp_smoothed,
   output logic                                      rsp_last_of_scan,
   output logic                                      rsp_short_scan,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [smar_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [smar_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import smar_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smooth_enable <= 1'b0;
         cfg_ff.smooth_radius <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SMOOTH_ENABLE: cfg_ff.smooth_enable <= csr_data[0];
            CSR_SMOOTH_RADIUS: cfg_ff.smooth_radius <= csr_data[RADIUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   smar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   smar_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .status           (status),
      .req_distance     (req_distance),
      .req_end_of_scan  (req_end_of_scan),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_smoothed     (rsp_smoothed),
      .rsp_last_of_scan (rsp_last_of_scan),
      .rsp_short_scan   (rsp_short_scan)
   );

   // an accepted sample keeps the input side closed while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after an accepted word");

   // a new result word never overwrites one still waiting
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result word overwritten while stalled");

   // the output only turns valid from a controller load
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_out))
      else $error("result valid without a load");

endmodule
`default_nettype wire

FILE: test/scan_moving_average_reflect_unit_tb.sv
// testbench for the scan smoother: streams scans, predicts every result word and checks it
`timescale 1ns / 1ps
module scan_moving_average_reflect_unit_tb;
   import smar_pkg::*;

   // time allowed for the longest smoothed word, plus margin
   localparam int SETTLE_CYCLES = 2 * MAX_RADIUS + 40;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] smoothed;
      logic                   last_of_scan;
      logic                   short_scan;
   } word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [SAMPLE_BITS-1:0]    req_distance = '0;
   logic                      req_end_of_scan = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [SAMPLE_BITS-1:0]    rsp_smoothed;
   logic                      rsp_last_of_scan;
   logic                      rsp_short_scan;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   scan_moving_average_reflect_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_distance     (req_distance),
      .req_end_of_scan  (req_end_of_scan),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_smoothed     (rsp_smoothed),
      .rsp_last_of_scan (rsp_last_of_scan),
      .rsp_short_scan   (rsp_short_scan),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // smoother state as the testbench sees it
   logic [SAMPLE_BITS-1:0] ring_copy [RING_DEPTH];
   logic [ADDR_BITS-1:0]   next_slot = '0;
   int                     scan_len = 0;
   logic                   enable_now = 1'b0;
   logic [RADIUS_BITS-1:0] radius_now = RADIUS_RESET;
   word_type               words_due [$];

   int  errors = 0;
   int  words_seen = 0;
   int  short_words = 0;
   int  samples_sent = 0;
   int  scans_sent = 0;
   int  burst_left = 0;
   bit  valid_held = 1'b0;

   function automatic logic [SAMPLE_BITS-1:0] sample_back(int back);
      logic [ADDR_BITS-1:0] slot;
      slot = ADDR_BITS'(int'(next_slot) - 1 - back);
      return ring_copy[slot];
   endfunction

   // mean of the 2k+1 window around scan position pos, mirrored at both edges
   function automatic logic [SAMPLE_BITS-1:0] window_mean(int n, int pos, int k);
      int total;
      int j;
      total = 0;
      for (int d = -k; d <= k; d++) begin
         j = pos + d;
         if (j < 0)
            j = -j;
         else if (j >= n)
            j = 2 * n - 2 - j;
         total += sample_back(n - 1 - j);
      end
      return SAMPLE_BITS'(total / (2 * k + 1));
   endfunction

   function automatic void add_word(logic [SAMPLE_BITS-1:0] value, logic last, logic short);
      word_type w;
      w.smoothed     = value;
      w.last_of_scan = last;
      w.short_scan   = short;
      words_due.push_back(w);
   endfunction

   function automatic void smooth_sample(logic [SAMPLE_BITS-1:0] range_mm, logic eos);
      int n;
      int k;
      k = radius_now;
      ring_copy[next_slot] = range_mm;
      next_slot = next_slot + 1'b1;
      if (scan_len < RING_DEPTH)
         scan_len++;
      n = scan_len;
      if (!enable_now) begin
         add_word(range_mm, eos, 1'b0);
         if (eos)
            scan_len = 0;
      end else if (eos) begin
         if (n <= k) begin
            // too short to smooth: replay the scan oldest first
            for (int b = n - 1; b >= 0; b--)
               add_word(sample_back(b), b == 0, 1'b1);
         end else begin
            for (int m = k; m >= 0; m--)
               add_word(window_mean(n, n - 1 - m, k), m == 0, 1'b0);
         end
         scan_len = 0;
      end else if (n >= k + 1) begin
         add_word(window_mean(n, n - 1 - k, k), 1'b0, 1'b0);
      end
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_distance();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] range_mm, input logic eos);
      req_valid       <= 1'b1;
      req_distance    <= range_mm;
      req_end_of_scan <= eos;
      do @(posedge clock); while (req_stall);
      smooth_sample(range_mm, eos);
      samples_sent++;
      if (eos)
         scans_sent++;
      if (burst_left > 0) begin
         burst_left--;
         valid_held = 1'b1;
      end else begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      end
   endtask

   task automatic drain_results();
      if (valid_held) begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
      end
      while (words_due.size() > 0)
         @(posedge clock);
      // a sample that makes no word may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_smoothing(input logic en, input logic [RADIUS_BITS-1:0] radius);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_SMOOTH_ENABLE;
      csr_data  <= CSR_DATA_BITS'(en);
      do @(posedge clock); while (!csr_ready);
      enable_now = en;
      csr_index <= CSR_SMOOTH_RADIUS;
      csr_data  <= radius;
      do @(posedge clock); while (!csr_ready);
      radius_now = radius;
      csr_valid <= 1'b0;
   endtask

   // settings from reset: smoothing off
   task automatic test_passthrough();
      send_sample('0, 1'b0);
      send_sample('1, 1'b0);
      send_sample(16'h5A5A, 1'b1);
      send_sample(16'hA5A5, 1'b1);
   endtask

   task automatic test_short_scans();
      set_smoothing(1'b1, 5'd1);
      send_sample(16'h1234, 1'b1);
      set_smoothing(1'b1, 5'd3);
      send_sample(16'h0042, 1'b1);
      // exactly k samples is still short
      send_sample('1, 1'b0);
      send_sample('0, 1'b0);
      send_sample('1, 1'b1);
      // k+1 samples: smallest scan that gets smoothed
      send_sample('1, 1'b0);
      send_sample('1, 1'b0);
      send_sample('0, 1'b0);
      send_sample('1, 1'b1);
   endtask

   task automatic test_radius_zero();
      set_smoothing(1'b1, 5'd0);
      send_sample('1, 1'b0);
      send_sample('0, 1'b0);
      send_sample(16'd1234, 1'b1);
      send_sample(16'd777, 1'b1);
   endtask

   task automatic test_mid_scan_changes();
      set_smoothing(1'b1, 5'd2);
      repeat (5) send_sample(random_distance(), 1'b0);
      set_smoothing(1'b1, 5'd4);
      send_sample(random_distance(), 1'b0);
      set_smoothing(1'b0, 5'd4);
      send_sample(random_distance(), 1'b0);
      set_smoothing(1'b1, 5'd1);
      send_sample(random_distance(), 1'b1);
   endtask

   task automatic test_random_scans();
      bit phase_en [6] = '{1, 1, 1, 0, 1, 1};
      int radii    [6] = '{1, 31, 0, 7, 2, 0};
      int quota    [6] = '{4, 1, 4, 4, 65, 4};
      int sent;
      int len;
      int k;
      for (int ph = 0; ph < 6; ph++) begin
         k = (ph == 5) ? $urandom_range(3, 14) : radii[ph];
         set_smoothing(phase_en[ph], RADIUS_BITS'(k));
         sent = 0;
         while (sent < quota[ph]) begin
            if (ph == 4)
               len = $urandom_range(65, 70);   // longer than the ring, count saturates
            else if (k > 0 && $urandom_range(0, 3) == 0)
               len = $urandom_range(1, k);
            else
               len = $urandom_range(1, k + 6);
            for (int i = 0; i < len; i++) begin
               send_sample(random_distance(), i == len - 1);
               sent++;
               // now and then a scan stays open across a settings change
               if (sent >= quota[ph] && $urandom_range(0, 3) == 0)
                  break;
            end
         end
      end
   endtask

   // receiver backpressure from a random stall pattern, renewed when the step counter wraps
   logic [31:0] stall_bits = '0;
   logic [4:0]  stall_step = '0;
   always @(posedge clock) begin
      stall_step <= stall_step + 1'b1;
      rsp_stall  <= stall_bits[stall_step];
      if (stall_step == 5'd31) begin
         case ($urandom_range(0, 3))
            0: stall_bits <= '0;
            1: stall_bits <= $urandom;
            2: stall_bits <= $urandom & $urandom;
            default: stall_bits <= $urandom | $urandom;
         endcase
      end
   end

   always @(posedge clock) begin
      word_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (words_due.size() == 0) begin
            $error("word with nothing due: smoothed %0d", rsp_smoothed);
            errors++;
         end else begin
            due = words_due.pop_front();
            if (due.short_scan)
               short_words++;
            if (rsp_smoothed !== due.smoothed) begin
               $error("smoothed: expected %0d, got %0d", due.smoothed, rsp_smoothed);
               errors++;
            end
            if (rsp_last_of_scan !== due.last_of_scan) begin
               $error("last_of_scan: expected %0d, got %0d", due.last_of_scan, rsp_last_of_scan);
               errors++;
            end
            if (rsp_short_scan !== due.short_scan) begin
               $error("short_scan: expected %0d, got %0d", due.short_scan, rsp_short_scan);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_passthrough();
      test_short_scans();
      test_radius_zero();
      test_mid_scan_changes();
      test_random_scans();
      drain_results();
      $display("sent %0d samples closing %0d scans, radius 0 to %0d, smoothing on and off",
               samples_sent, scans_sent, MAX_RADIUS);
      $display("checked %0d words, %0d of them replayed from short scans",
               words_seen, short_words);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #30_000_000;
      $error("run did not finish in time, %0d words still due", words_due.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
